@@ sv/lsd_pkg.sv @@
// shared types and constants for the decimal radix sorter
// no dependencies
package lsd_pkg;
  localparam int unsigned ValW   = 31;
  localparam int unsigned Radix  = 10;
  localparam int unsigned DigW   = 4;

  typedef logic [ValW-1:0] val_t;
  typedef logic [DigW-1:0] dig_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // write incoming beat into the store
    logic clr_set;     // clear count, max, lost flag, buffer select and place
    logic clr_bkt;     // zero bucket counters and prefix sum
    logic cnt_en;      // count digit of read data
    logic pfx_en;      // prefix step at bucket idx
    logic plc_en;      // place read data into destination
    logic next_place;  // advance place, swap buffers
    logic emit_ld;     // load output register from read data
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic idx_last;    // idx == count-1
    logic bkt_last;    // idx == 9
    logic more_pass;   // max / place > 0
  } sts_t;
endpackage

@@ sv/lsd_ram.sv @@
// generic single port write, single port read ram, registered read
// no dependencies
module lsd_ram #(
  parameter int W = 31,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/lsd_datapath.sv @@
// stores, bucket counters and digit extraction for the sorter
// depends on lsd_pkg and lsd_ram
module lsd_datapath import lsd_pkg::*; #(
  parameter int SET_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  val_t       in_value,
  output val_t       rd_value,
  output logic       lost,
  output logic [$clog2(SET_DEPTH+1)-1:0] count_out
);
  localparam int AW = $clog2(SET_DEPTH);
  localparam int CW = $clog2(SET_DEPTH+1);
  localparam int IW = (CW > DigW) ? CW : DigW;
  localparam int EW = 2 * ValW;

  logic [CW-1:0] count_r;
  val_t max_r;
  logic lost_r;
  logic [IW-1:0] idx_r;
  logic sel_r;               // 0: buffer a is source
  logic [33:0] place_r;      // up to 10^10
  logic [CW-1:0] bkt_r [Radix];
  logic [CW-1:0] sum_r;
  logic [CW-1:0] nxt_sum;
  logic [CW-1:0] cur_b;
  logic [AW-1:0] rdaddr;
  logic [EW-1:0] rda, rdb, rdat;
  val_t rval;                // stored value
  val_t rquo;                // stored value / place
  logic [62:0] prod;
  val_t q10;
  val_t tens;
  val_t rem;
  dig_t dig;
  logic [AW-1:0] dst;
  logic full;
  logic we_a, we_b;
  logic [AW-1:0] wa_a, wa_b;
  logic [EW-1:0] wd_a, wd_plc;

  assign rdaddr = idx_r[AW-1:0];
  assign rdat = sel_r ? rdb : rda;
  assign rval = rdat[ValW-1:0];
  assign rquo = rdat[EW-1:ValW];
  assign rd_value = rval;
  assign lost = lost_r;
  assign count_out = count_r;
  assign full = (count_r == CW'(SET_DEPTH));

  // each entry carries the value and its quotient by the current place;
  // the digit is quotient mod 10 and placement stores quotient / 10
  assign prod = 63'(rquo) * 63'(32'hCCCCCCCD);
  assign q10 = {3'b0, prod[62:35]};
  assign tens = {q10[ValW-4:0], 3'b0} + {q10[ValW-2:0], 1'b0};
  assign rem = rquo - tens;
  assign dig = rem[DigW-1:0];
  assign wd_plc = {q10, rval};

  assign cur_b = bkt_r[dig];
  assign dst = cur_b[AW-1:0];
  assign wa_b = dst;

  always_comb begin
    we_a = 1'b0; we_b = 1'b0;
    wa_a = count_r[AW-1:0];
    wd_a = {in_value, in_value};
    if (cmd.load) begin
      we_a = !full;
    end else if (cmd.plc_en) begin
      wa_a = dst; wd_a = wd_plc;
      if (sel_r) we_a = 1'b1; else we_b = 1'b1;
    end
  end

  lsd_ram #(.W(EW), .D(SET_DEPTH)) u_a (
    .clk(clk), .we(we_a), .waddr(wa_a), .wdata(wd_a), .raddr(rdaddr), .rdata(rda));
  lsd_ram #(.W(EW), .D(SET_DEPTH)) u_b (
    .clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_plc), .raddr(rdaddr), .rdata(rdb));

  assign nxt_sum = sum_r + bkt_r[idx_r[DigW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; max_r <= '0; lost_r <= 1'b0; idx_r <= '0;
      sel_r <= 1'b0; place_r <= 34'd1; sum_r <= '0;
      for (int i = 0; i < Radix; i++) bkt_r[i] <= '0;
    end else begin
      if (cmd.load) begin
        if (full) lost_r <= 1'b1;
        else begin
          count_r <= count_r + 1'b1;
          if (in_value > max_r) max_r <= in_value;
        end
      end
      if (cmd.clr_set) begin
        count_r <= '0; max_r <= '0; lost_r <= 1'b0; sel_r <= 1'b0;
        place_r <= 34'd1;
      end
      if (cmd.clr_bkt) begin
        for (int i = 0; i < Radix; i++) bkt_r[i] <= '0;
        sum_r <= '0;
      end
      if (cmd.cnt_en) bkt_r[dig] <= cur_b + 1'b1;
      if (cmd.pfx_en) begin
        bkt_r[idx_r[DigW-1:0]] <= sum_r;
        sum_r <= nxt_sum;
      end
      if (cmd.plc_en) bkt_r[dig] <= cur_b + 1'b1;
      if (cmd.next_place) begin
        place_r <= {place_r[30:0], 3'b0} + {place_r[32:0], 1'b0};
        sel_r <= ~sel_r;
      end
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  assign sts.idx_last = (idx_r == IW'(count_r) - 1'b1);
  assign sts.bkt_last = (idx_r == IW'(Radix-1));
  assign sts.more_pass = ({3'b0, max_r} >= place_r);
endmodule

@@ sv/lsd_ctrl.sv @@
// sequencer: load, per-digit count, prefix, place, then emit
// depends on lsd_pkg
module lsd_ctrl import lsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_last,
  input  logic out_free,     // output register free or being taken
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic emit_last
);
  localparam logic [2:0] S_LOAD = 3'd0, S_CNT = 3'd1, S_PFX = 3'd2,
                         S_PLC = 3'd3, S_CHK = 3'd4, S_EMIT = 3'd5, S_START = 3'd6;
  logic [2:0] st_r, st_nxt;
  logic ph_r, ph_nxt;   // 0: read issued, 1: data present

  always_comb begin
    cmd = '0; st_nxt = st_r; ph_nxt = ph_r; in_ready = 1'b0; emit_last = 1'b0;
    unique case (st_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire && in_last) begin st_nxt = S_START; end
      end
      S_START: begin
        cmd.idx_clr = 1'b1; cmd.clr_bkt = 1'b1; ph_nxt = 1'b0;
        st_nxt = sts.more_pass ? S_CNT : S_EMIT;
      end
      S_CNT: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.cnt_en = 1'b1; ph_nxt = 1'b0;
          if (sts.idx_last) begin cmd.idx_clr = 1'b1; st_nxt = S_PFX; end
          else cmd.idx_inc = 1'b1;
        end
      end
      S_PFX: begin
        cmd.pfx_en = 1'b1;
        if (sts.bkt_last) begin cmd.idx_clr = 1'b1; st_nxt = S_PLC; end
        else cmd.idx_inc = 1'b1;
      end
      S_PLC: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.plc_en = 1'b1; ph_nxt = 1'b0;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1; cmd.next_place = 1'b1; st_nxt = S_CHK;
          end else cmd.idx_inc = 1'b1;
        end
      end
      S_CHK: begin
        cmd.clr_bkt = 1'b1;
        st_nxt = sts.more_pass ? S_CNT : S_EMIT;
      end
      S_EMIT: begin
        if (!ph_r) ph_nxt = 1'b1;
        else if (out_free) begin
          cmd.emit_ld = 1'b1; ph_nxt = 1'b0;
          emit_last = sts.idx_last;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1; cmd.clr_set = 1'b1; st_nxt = S_LOAD;
          end else cmd.idx_inc = 1'b1;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin st_r <= S_LOAD; ph_r <= 1'b0; end
    else begin st_r <= st_nxt; ph_r <= ph_nxt; end
  end
endmodule

@@ sv/lsd_decimal_radix_sorter.sv @@
// Decimal LSD radix sorter.
// Input beats carry one value each; a beat with tlast high closes the set.
// Up to SET_DEPTH values are kept; further values are dropped and every
// result of that set carries the overflow flag in out_tuser.
// Loading accepts one beat per cycle. After the closing beat the block sorts
// with one bucket pass per decimal digit of the largest value (none when
// the largest is zero). A pass counts the digits of all values, forms the
// ten bucket starts, places every value and then checks for another digit;
// each value in the count, place and emit sweeps needs a read of the store
// RAM before its registered data is used. Results then leave ascending,
// with tlast on the last.
// in_tready is low from the closing beat until the last result is loaded
// into the output register. A stalled receiver holds the output register
// and pauses emission; nothing is lost.
// Reset empties the set and drops the output valid; store contents
// need no clearing.
// depends on lsd_pkg, lsd_ctrl, lsd_datapath, lsd_ram
module lsd_decimal_radix_sorter import lsd_pkg::*; #(
  parameter int SET_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value
  input  logic        in_tlast,   // final_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] sorted_value
  output logic        out_tlast,  // end_of_run
  output logic        out_tuser   // overflow
);
  cmd_t cmd;
  sts_t sts;
  val_t rdv;
  logic lost, emit_last, out_free, in_fire;
  logic [$clog2(SET_DEPTH+1)-1:0] cnt;
  logic vld_r; val_t dat_r; logic last_r, ovf_r;

  assign in_fire = in_tvalid && in_tready;
  assign out_free = !vld_r || out_tready;

  lsd_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_tlast),
    .out_free(out_free), .sts(sts), .cmd(cmd), .in_ready(in_tready),
    .emit_last(emit_last));

  lsd_datapath #(.SET_DEPTH(SET_DEPTH)) u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd),
    .sts(sts), .in_value(in_tdata[30:0]), .rd_value(rdv), .lost(lost),
    .count_out(cnt));

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (cmd.emit_ld) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
    if (cmd.emit_ld) begin
      dat_r <= rdv; last_r <= emit_last; ovf_r <= lost && (cnt != '0);
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {1'b0, dat_r};
  assign out_tlast = last_r;
  assign out_tuser = ovf_r;
endmodule
